// File: hdl/arrip_pkg.sv
// arrip_pkg: shared types and constants for the adaptive rrip replacement block
// no dependencies
package arrip_pkg;
	localparam int unsigned CNT_W = 16;
	localparam int unsigned TOL_W = 12;
	localparam logic [1:0] RRPV_MAX = 2'd3;
	localparam logic [1:0] RRPV_INSERT = 2'd2;

	typedef enum logic [1:0] {
		MODE_SRRIP = 2'd0,
		MODE_BIP = 2'd1,
		MODE_SPATIAL = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		CFG_ADAPT_PERIOD = 2'd0,
		CFG_SPATIAL_MIN = 2'd1,
		CFG_STRIDE_TOL = 2'd2
	} cfg_idx_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;     // capture the request
		logic rd;       // issue memory reads
		logic calc;     // compute new set state
		logic wr;       // write back and build result
	} arrip_cmd_t;

	typedef struct packed {
		logic clr_done;
	} arrip_sts_t;
endpackage

// File: hdl/arrip_if.sv
// arrip_if: valid/ready channel interfaces for items and configuration writes
// no dependencies
interface arrip_in_if #(parameter int SET_W = 11, parameter int ADDR_BITS = 48);
	logic valid;
	logic ready;
	logic kind;
	logic [SET_W-1:0] set_index;
	logic [3:0] way;
	logic [ADDR_BITS-1:0] address;
	logic hit;
	modport source (output valid, kind, set_index, way, address, hit, input ready);
	modport sink (input valid, kind, set_index, way, address, hit, output ready);
endinterface

interface arrip_out_if;
	logic valid;
	logic ready;
	logic [3:0] victim_way;
	logic [1:0] set_mode;
	modport source (output valid, victim_way, set_mode, input ready);
	modport sink (input valid, victim_way, set_mode, output ready);
endinterface

interface arrip_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/arrip_ctrl.sv
// arrip_ctrl: sequencer for clearing pass and per-item read, compute, write
// depends on arrip_pkg
module arrip_ctrl import arrip_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  arrip_sts_t sts,
	output arrip_cmd_t cmd
);
	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CALC, S_WRITE, S_OUT} state_t;
	state_t state_q;

	assign in_ready = (state_q == S_IDLE) || (state_q == S_OUT && out_ready);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.rd = (state_q == S_READ);
		cmd.calc = (state_q == S_CALC);
		cmd.wr = (state_q == S_WRITE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			case (state_q)
				S_CLEAR: if (sts.clr_done) state_q <= S_IDLE;
				S_IDLE: if (in_valid) state_q <= S_READ;
				S_READ: state_q <= S_CALC;
				S_CALC: state_q <= S_WRITE;
				S_WRITE: state_q <= S_OUT;
				S_OUT: begin
					if (out_ready) state_q <= in_valid ? S_READ : S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: hdl/arrip_dp.sv
// arrip_dp: set state memories, victim search, stride history and mode decision
// depends on arrip_pkg
module arrip_dp import arrip_pkg::*; #(
	parameter int SETS = 2048,
	parameter int WAYS = 16,
	parameter int ADDR_BITS = 48,
	parameter int SET_W = 11
) (
	input  logic clk,
	input  logic arst_n,
	input  arrip_cmd_t cmd,
	output arrip_sts_t sts,
	input  logic kind,
	input  logic [SET_W-1:0] set_index,
	input  logic [3:0] way,
	input  logic [ADDR_BITS-1:0] address,
	input  logic hit,
	input  logic [CNT_W-1:0] adapt_period,
	input  logic [CNT_W-1:0] spatial_min,
	input  logic [TOL_W-1:0] stride_tol,
	output logic [3:0] victim_way,
	output logic [1:0] set_mode
);
	localparam int SI_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int SW = ADDR_BITS + 1;
	// stride difference needs one bit more than a stride
	localparam int DW = SW + 1;
	localparam int PW = CNT_W + 3;
	localparam int RW = 2 * WAYS;
	// per-set meta: slot, four counters, mode
	localparam int MW = 2 + 4 * CNT_W + 2;

	logic [RW-1:0] rrpv_mem [SETS];
	logic [4*ADDR_BITS-1:0] addr_mem [SETS];
	logic [3*SW-1:0] strd_mem [SETS];
	logic [MW-1:0] meta_mem [SETS];

	logic [SI_W:0] clr_q;
	logic kind_q, hit_q;
	logic [SI_W-1:0] set_q;
	logic [3:0] way_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [RW-1:0] rrpv_s1;
	logic [4*ADDR_BITS-1:0] addr_s1;
	logic [3*SW-1:0] strd_s1;
	logic [MW-1:0] meta_s1;
	logic [RW-1:0] rrpv_s2;
	logic [4*ADDR_BITS-1:0] addr_s2;
	logic [3*SW-1:0] strd_s2;
	logic [MW-1:0] meta_s2;
	logic [3:0] vic_s2;
	logic [4:0] bim_q;
	logic [4:0] bim_s2;

	logic [SI_W-1:0] set_in;
	assign set_in = SI_W'(set_index % SETS);
	assign sts.clr_done = clr_q[SI_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			bim_q <= '0;
		end else begin
			if (!clr_q[SI_W]) begin
				clr_q <= (clr_q[SI_W-1:0] == SI_W'(SETS - 1)) ?
					{1'b1, {SI_W{1'b0}}} : clr_q + 1'b1;
			end
			if (cmd.wr) bim_q <= bim_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			set_q <= set_in;
			way_q <= way;
			addr_q <= address;
			hit_q <= hit;
		end
		if (cmd.rd) begin
			rrpv_s1 <= rrpv_mem[set_q];
			addr_s1 <= addr_mem[set_q];
			strd_s1 <= strd_mem[set_q];
			meta_s1 <= meta_mem[set_q];
		end
		if (!clr_q[SI_W]) begin
			rrpv_mem[clr_q[SI_W-1:0]] <= '1;
			addr_mem[clr_q[SI_W-1:0]] <= '0;
			strd_mem[clr_q[SI_W-1:0]] <= '0;
			meta_mem[clr_q[SI_W-1:0]] <= '0;
		end else if (cmd.wr) begin
			rrpv_mem[set_q] <= rrpv_s2;
			addr_mem[set_q] <= addr_s2;
			strd_mem[set_q] <= strd_s2;
			meta_mem[set_q] <= meta_s2;
		end
	end

	// compute stage
	logic [1:0] mx;
	logic [1:0] age;
	logic [RW-1:0] aged;
	logic [3:0] pick;
	logic found;
	logic [1:0] slot;
	logic [CNT_W-1:0] pa, ph, sa, sh;
	logic [1:0] mode;
	logic [ADDR_BITS-1:0] prev;
	logic [SW-1:0] stride;
	logic [SW-1:0] st [3];
	logic [3*SW-1:0] strd_n;
	logic [4*ADDR_BITS-1:0] addr_n;
	logic spatial;
	logic [DW-1:0] dif;
	logic [PW-1:0] sh5, sa3, ph5, pa2;
	logic [1:0] mode_n;
	logic [4:0] bim_n;
	logic [1:0] v;
	logic [RW-1:0] rrpv_n;

	always_comb begin
		mx = '0;
		for (int w = 0; w < WAYS; w++)
			if (rrpv_s1[2*w +: 2] > mx) mx = rrpv_s1[2*w +: 2];
		age = RRPV_MAX - mx;
		found = 1'b0;
		pick = '0;
		for (int w = 0; w < WAYS; w++) begin
			aged[2*w +: 2] = rrpv_s1[2*w +: 2] + age;
			if (!found && rrpv_s1[2*w +: 2] == mx) begin
				found = 1'b1;
				pick = 4'(w);
			end
		end
		{slot, pa, ph, sa, sh, mode} = meta_s1;
		pa = (pa == '1) ? pa : pa + 1'b1;
		if (hit_q && ph != '1) ph = ph + 1'b1;
		prev = addr_s1[ADDR_BITS*slot +: ADDR_BITS];
		stride = {1'b0, addr_q} - {1'b0, prev};
		strd_n = strd_s1;
		if (slot != 2'd0) strd_n[SW*(slot-2'd1) +: SW] = stride;
		addr_n = addr_s1;
		addr_n[ADDR_BITS*slot +: ADDR_BITS] = addr_q;
		for (int i = 0; i < 3; i++) st[i] = strd_n[SW*i +: SW];
		spatial = (pa > CNT_W'(4));
		dif = '0;
		for (int i = 1; i < 3; i++) begin
			dif = {st[i][SW-1], st[i]} - {st[0][SW-1], st[0]};
			if (dif[DW-1]) dif = -dif;
			if (dif > DW'(stride_tol)) spatial = 1'b0;
		end
		if (spatial) begin
			if (sa != '1) sa = sa + 1'b1;
			if (hit_q && sh != '1) sh = sh + 1'b1;
		end
		mode_n = mode;
		sh5 = {3'b0, sh} * PW'(5);
		sa3 = {3'b0, sa} * PW'(3);
		ph5 = {3'b0, ph} * PW'(5);
		pa2 = {3'b0, pa} * PW'(2);
		if (pa >= adapt_period) begin
			if (sh5 > sa3 && sa > spatial_min) mode_n = MODE_SPATIAL;
			else if (ph5 > pa2) mode_n = MODE_SRRIP;
			else mode_n = MODE_BIP;
			pa = '0; ph = '0; sa = '0; sh = '0;
		end
		bim_n = bim_q;
		if (hit_q) v = 2'd0;
		else if (mode_n == MODE_SRRIP) v = RRPV_INSERT;
		else if (mode_n == MODE_BIP) begin
			bim_n = bim_q + 1'b1;
			v = (bim_n == '0) ? RRPV_INSERT : RRPV_MAX;
		end else v = 2'd0;
		rrpv_n = rrpv_s1;
		if (32'(way_q) < WAYS) rrpv_n[2*way_q +: 2] = v;
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			if (!kind_q) begin
				rrpv_s2 <= aged;
				addr_s2 <= addr_s1;
				strd_s2 <= strd_s1;
				meta_s2 <= meta_s1;
				vic_s2 <= pick;
				bim_s2 <= bim_q;
			end else begin
				rrpv_s2 <= rrpv_n;
				addr_s2 <= addr_n;
				strd_s2 <= strd_n;
				meta_s2 <= {slot + 2'd1, pa, ph, sa, sh, mode_n};
				vic_s2 <= '0;
				bim_s2 <= bim_n;
			end
		end
		if (cmd.wr) begin
			victim_way <= vic_s2;
			set_mode <= meta_s2[1:0];
		end
	end
endmodule

// File: hdl/adaptive_rrip_replacement_top.sv
// adaptive_rrip_replacement_top: top level, config registers, ctrl and datapath
// depends on arrip_pkg, arrip_if, arrip_ctrl, arrip_dp
// Usage:
//  in_ch carries one item: a find-victim (kind 0) or an update (kind 1) for a set.
//  out_ch returns exactly one item per input: victim_way and set_mode.
//  cfg_ch writes adapt_period (0), spatial_min_count (1), stride_tolerance (2);
//  it is always ready and should be written only while the block is idle.
//  After acceptance an item passes the read, compute and write states before out
//  valid rises; the result is registered in the write state.
//  No new item is taken until the previous result is taken, owing to the
//  single-port read-modify-write of the per-set memories.
//  A new item is accepted in the cycle the previous result is taken.
//  After reset a clearing pass writes every entry of the set memories in turn;
//  in_ch ready stays low until it ends. Config writes are taken throughout.
//  When the receiver stalls the result holds and no new item is accepted.
module adaptive_rrip_replacement_top import arrip_pkg::*; #(
	parameter int SETS = 2048,
	parameter int WAYS = 16,
	parameter int ADDR_BITS = 48
) (
	input logic clk,
	input logic arst_n,
	arrip_in_if.sink in_ch,
	arrip_out_if.source out_ch,
	arrip_cfg_if.sink cfg_ch
);
	localparam int SET_W = 11;
	logic [CNT_W-1:0] adapt_period_q, spatial_min_q;
	logic [TOL_W-1:0] stride_tol_q;
	arrip_cmd_t cmd;
	arrip_sts_t sts;

	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adapt_period_q <= 16'd2048;
			spatial_min_q <= 16'd100;
			stride_tol_q <= 12'd64;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				CFG_ADAPT_PERIOD: adapt_period_q <= cfg_ch.data;
				CFG_SPATIAL_MIN: spatial_min_q <= cfg_ch.data;
				CFG_STRIDE_TOL: stride_tol_q <= cfg_ch.data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	arrip_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	arrip_dp #(.SETS(SETS), .WAYS(WAYS), .ADDR_BITS(ADDR_BITS), .SET_W(SET_W)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.kind(in_ch.kind), .set_index(in_ch.set_index), .way(in_ch.way),
		.address(in_ch.address), .hit(in_ch.hit),
		.adapt_period(adapt_period_q), .spatial_min(spatial_min_q),
		.stride_tol(stride_tol_q),
		.victim_way(out_ch.victim_way), .set_mode(out_ch.set_mode)
	);

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!sts.clr_done |-> !in_ch.ready) else $error("item taken during clear");
	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.set_mode != 2'd3) else $error("bad set mode");
	a_accept_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !out_ch.valid) else $error("result too early");
endmodule

// File: dv/tb_if_note.sv
`timescale 1ns / 1ps
// arrip_tb_types: item and result records shared by the testbench top
// depends on arrip_pkg for the insertion mode type
package arrip_tb_types;
	import arrip_pkg::*;

	typedef struct packed {
		logic kind;
		logic [10:0] set_index;
		logic [3:0] way;
		logic [47:0] address;
		logic hit;
	} access_t;

	typedef struct packed {
		logic [3:0] victim_way;
		mode_t set_mode;
	} decision_t;
endpackage

// File: dv/testbench.sv
`timescale 1ns / 1ps
// testbench: random and directed check of the adaptive rrip replacement block
// depends on arrip_pkg, arrip_if, arrip_tb_types and adaptive_rrip_replacement_top
module testbench;
	import arrip_pkg::*;
	import arrip_tb_types::*;

	localparam int SETS = 2048;
	localparam int WAYS = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	arrip_in_if #(.SET_W(11), .ADDR_BITS(48)) in_ch();
	arrip_out_if out_ch();
	arrip_cfg_if cfg_ch();

	adaptive_rrip_replacement_top #(.SETS(SETS), .WAYS(WAYS), .ADDR_BITS(48)) u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	logic [1:0] rrpv_q [SETS][WAYS];
	logic [47:0] addr_hist [SETS][4];
	logic signed [48:0] stride_hist [SETS][3];
	logic [1:0] slot_q [SETS];
	int unsigned acc_cnt [SETS], hit_cnt [SETS], sp_acc [SETS], sp_hit [SETS];
	mode_t mode_q [SETS];
	logic [4:0] bip_cnt;
	int unsigned period_cfg, spmin_cfg, tol_cfg;

	access_t pending_q [$];
	decision_t expected_q [$];
	int accepted, received, errors;
	int n_find, n_upd, n_spatial_mode, n_bip_mode;
	bit hold_rx;

	function automatic int unsigned sat16(int unsigned v);
		return v < 65535 ? v + 1 : 65535;
	endfunction

	function automatic decision_t predict(access_t a);
		decision_t d;
		int s;
		logic [1:0] mx, nv;
		logic [1:0] sl;
		logic signed [48:0] st;
		logic signed [49:0] df;
		bit sp;
		longint unsigned sh, sa, ph, pa;
		s = a.set_index;
		d.victim_way = '0;
		if (!a.kind) begin
			mx = 0;
			for (int w = 0; w < WAYS; w++) if (rrpv_q[s][w] > mx) mx = rrpv_q[s][w];
			for (int w = 0; w < WAYS; w++) rrpv_q[s][w] = rrpv_q[s][w] + (RRPV_MAX - mx);
			for (int w = WAYS - 1; w >= 0; w--)
				if (rrpv_q[s][w] == RRPV_MAX) d.victim_way = w[3:0];
		end else begin
			acc_cnt[s] = sat16(acc_cnt[s]);
			if (a.hit) hit_cnt[s] = sat16(hit_cnt[s]);
			sl = slot_q[s];
			st = $signed({1'b0, a.address}) - $signed({1'b0, addr_hist[s][sl]});
			if (sl != 0) stride_hist[s][sl - 1] = st;
			addr_hist[s][sl] = a.address;
			slot_q[s] = sl + 1;
			sp = 0;
			if (acc_cnt[s] > 4) begin
				sp = 1;
				for (int i = 0; i < 3; i++) begin
					df = stride_hist[s][i] - stride_hist[s][0];
					if (df < 0) df = -df;
					if (df > $signed({38'd0, tol_cfg[11:0]})) sp = 0;
				end
			end
			if (sp) begin
				sp_acc[s] = sat16(sp_acc[s]);
				if (a.hit) sp_hit[s] = sat16(sp_hit[s]);
			end
			if (acc_cnt[s] >= period_cfg) begin
				sh = sp_hit[s]; sa = sp_acc[s]; ph = hit_cnt[s]; pa = acc_cnt[s];
				if (5 * sh > 3 * sa && sa > spmin_cfg) mode_q[s] = MODE_SPATIAL;
				else if (5 * ph > 2 * pa) mode_q[s] = MODE_SRRIP;
				else mode_q[s] = MODE_BIP;
				acc_cnt[s] = 0; hit_cnt[s] = 0; sp_acc[s] = 0; sp_hit[s] = 0;
			end
			if (a.hit) nv = 0;
			else if (mode_q[s] == MODE_SRRIP) nv = RRPV_INSERT;
			else if (mode_q[s] == MODE_BIP) begin
				bip_cnt = bip_cnt + 1;
				nv = bip_cnt == 0 ? RRPV_INSERT : RRPV_MAX;
			end else nv = 0;
			if (a.way < WAYS) rrpv_q[s][a.way] = nv;
		end
		d.set_mode = mode_q[s];
		return d;
	endfunction

	// driver
	int gap_left;
	initial begin
		in_ch.valid = 0; in_ch.kind = 0; in_ch.set_index = 0; in_ch.way = 0;
		in_ch.address = 0; in_ch.hit = 0;
		cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
		out_ch.ready = 0;
		gap_left = 0;
	end

	function automatic int rand_gap();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
			(($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				expected_q.push_back(predict({in_ch.kind, in_ch.set_index, in_ch.way,
					in_ch.address, in_ch.hit}));
				accepted <= accepted + 1;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0 || pending_q.size() == 0) begin
					in_ch.valid <= 1'b0;
					if (gap_left > 0) gap_left <= gap_left - 1;
				end else begin
					access_t a;
					a = pending_q.pop_front();
					in_ch.valid <= 1'b1;
					{in_ch.kind, in_ch.set_index, in_ch.way, in_ch.address, in_ch.hit} <= a;
					gap_left <= rand_gap();
				end
			end
		end
	end

	// monitor and receiver stalls
	int rx_gap;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				decision_t e;
				received <= received + 1;
				if (expected_q.size() == 0) begin
					errors = errors + 1;
					if (errors <= 10) $display("unexpected result victim=%0d mode=%0d",
						out_ch.victim_way, out_ch.set_mode);
				end else begin
					e = expected_q.pop_front();
					if (e.victim_way !== out_ch.victim_way || e.set_mode !== out_ch.set_mode) begin
						errors = errors + 1;
						if (errors <= 10)
							$display("mismatch: exp victim=%0d mode=%0d got victim=%0d mode=%0d",
								e.victim_way, e.set_mode, out_ch.victim_way, out_ch.set_mode);
					end
					if (e.set_mode == MODE_SPATIAL) n_spatial_mode++;
					if (e.set_mode == MODE_BIP) n_bip_mode++;
				end
			end
			if (hold_rx) out_ch.ready <= 1'b0;
			else if (rx_gap > 0) begin
				out_ch.ready <= 1'b0;
				rx_gap <= rx_gap - 1;
			end else begin
				out_ch.ready <= 1'b1;
				rx_gap <= rand_gap();
			end
		end
	end

	task automatic cfg_write(cfg_idx_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			CFG_ADAPT_PERIOD: period_cfg = val;
			CFG_SPATIAL_MIN: spmin_cfg = val;
			default: tol_cfg = val[11:0];
		endcase
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || in_ch.valid || expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic access_t upd(int s, int w, logic [47:0] ad, bit h);
		access_t a;
		a.kind = 1; a.set_index = s; a.way = w; a.address = ad; a.hit = h;
		return a;
	endfunction

	function automatic access_t fnd(int s);
		access_t a;
		a = '0;
		a.set_index = s;
		a.address = {$urandom, $urandom};
		a.way = $urandom; a.hit = $urandom;
		return a;
	endfunction

	// stride run into one set, random hits; most of the random traffic
	task automatic stride_burst(int s, int len);
		logic [47:0] base;
		int step;
		base = {$urandom, $urandom};
		step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : 64;
		for (int i = 0; i < len; i++) begin
			pending_q.push_back(upd(s, $urandom_range(0, 15),
				base + i * step + $urandom_range(0, tol_cfg / 4), $urandom_range(0, 3) != 0));
			if ($urandom_range(0, 4) == 0) pending_q.push_back(fnd(s));
		end
	endtask

	task automatic random_phase(int n);
		int s;
		for (int i = 0; i < n; ) begin
			s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 7);
			case ($urandom_range(0, 3))
				0: begin
					pending_q.push_back(fnd(s));
					i++;
				end
				1: begin
					pending_q.push_back(upd(s, $urandom, {$urandom, $urandom}, $urandom));
					i++;
				end
				default: begin
					stride_burst(s, 8);
					i += 8;
				end
			endcase
		end
	endtask

	initial begin
		accepted = 0; received = 0; errors = 0; hold_rx = 0; rx_gap = 0;
		bip_cnt = 0; period_cfg = 2048; spmin_cfg = 100; tol_cfg = 64;
		for (int s = 0; s < SETS; s++) begin
			for (int w = 0; w < WAYS; w++) rrpv_q[s][w] = RRPV_MAX;
			for (int i = 0; i < 4; i++) addr_hist[s][i] = 0;
			for (int i = 0; i < 3; i++) stride_hist[s][i] = 0;
			slot_q[s] = 0; acc_cnt[s] = 0; hit_cnt[s] = 0; sp_acc[s] = 0; sp_hit[s] = 0;
			mode_q[s] = MODE_SRRIP;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes of fields, victims with aging, all insert paths
		pending_q.push_back(fnd(0));
		pending_q.push_back(fnd(2047));
		pending_q.push_back(upd(0, 0, 48'hFFFF_FFFF_FFFF, 1));
		pending_q.push_back(upd(0, 15, 48'h0, 0));
		pending_q.push_back(fnd(0));
		pending_q.push_back(upd(2047, 15, 48'hAAAA_5555_AAAA, 1));
		pending_q.push_back(upd(2047, 3, 48'h5555_AAAA_5555, 0));
		pending_q.push_back(fnd(2047));
		drain();
		cfg_write(CFG_ADAPT_PERIOD, 16'd1);
		cfg_write(CFG_SPATIAL_MIN, 16'd0);
		cfg_write(CFG_STRIDE_TOL, 16'd4095);
		// every access decides: a miss goes to BIP, and hits with strides go to SRRIP
		pending_q.push_back(upd(5, 1, 48'h100, 0));
		pending_q.push_back(upd(5, 2, 48'h200, 0));
		for (int i = 0; i < 6; i++) pending_q.push_back(upd(6, i, 48'h1000 + i * 64, 1));
		for (int i = 0; i < 3; i++) pending_q.push_back(fnd(5));
		drain();
		cfg_write(CFG_ADAPT_PERIOD, 16'd8);
		cfg_write(CFG_STRIDE_TOL, 16'd0);
		for (int i = 0; i < 12; i++) pending_q.push_back(upd(7, 15, 48'h40 * i, 1));
		pending_q.push_back(fnd(7));
		drain();

		// long receiver hold while items keep coming
		random_phase(40);
		hold_rx = 1;
		repeat (60) @(posedge clk);
		hold_rx = 0;
		drain();

		cfg_write(CFG_ADAPT_PERIOD, 16'd16);
		cfg_write(CFG_SPATIAL_MIN, 16'd2);
		cfg_write(CFG_STRIDE_TOL, 16'd64);
		random_phase(160);
		drain();
		cfg_write(CFG_ADAPT_PERIOD, 16'd65535);
		cfg_write(CFG_SPATIAL_MIN, 16'd65535);
		cfg_write(CFG_STRIDE_TOL, 16'd4095);
		random_phase(80);
		drain();
		cfg_write(CFG_ADAPT_PERIOD, 16'd5);
		cfg_write(CFG_SPATIAL_MIN, 16'd1);
		cfg_write(CFG_STRIDE_TOL, 16'd16);
		random_phase(160);
		drain();

		$display("covered %0d items, %0d results; spatial-mode results %0d, bip-mode results %0d",
			accepted, received, n_spatial_mode, n_bip_mode);
		if (errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end
endmodule
